// File: hdl/hartigan_kmeans_reassign_top_macros.svh
// Assertion macros for the k-means reassignment block checker
`ifndef HARTIGAN_KMEANS_REASSIGN_TOP_MACROS_SVH
`define HARTIGAN_KMEANS_REASSIGN_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define HKR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define HKR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// state in the cycle after reset is seen
`define HKR_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

// File: hdl/hkr_pkg.sv
// Shared constants, types and codes of the k-means reassignment block
package hkr_pkg;
  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_FEATURES = 64;
  localparam int SIZE_BITS    = 24;
  localparam int CL_W         = 4;
  localparam int FI_W         = 6;
  localparam int VAL_W        = 32;
  localparam int SUM_W        = 48;
  localparam int COST_W       = 64;
  localparam int CNT_W        = 24;
  localparam int NC_W         = 5;
  localparam int NF_W         = 7;
  localparam int DIVN_W       = 88;
  localparam int DIVD_W       = 25;
  localparam int DCNT_W       = 7;
  localparam int IN_DATA_W    = 48;
  localparam int OUT_DATA_W   = 232;

  localparam logic REG_CLUSTERS = 1'b0;
  localparam logic REG_FEATURES = 1'b1;

  typedef enum logic [1:0] {
    CMD_INIT     = 2'd0,
    CMD_MOVE     = 2'd1,
    CMD_CLASSIFY = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [FI_W-1:0]  idx;
    logic [VAL_W-1:0] data;
  } smp_wr_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [CL_W-1:0] label;
    logic            bank;
  } job_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_ADD_RD,
    BK_ADD_WR,
    BK_ADD_END,
    BK_C_START,
    BK_C_RD,
    BK_C_DIV,
    BK_C_DIVW,
    BK_C_SQ,
    BK_C_ACC,
    BK_C_M0,
    BK_C_M1,
    BK_C_FDIV,
    BK_C_FDIVW,
    BK_C_NEXT,
    BK_C_END,
    BK_EMIT
  } bk_state_t;
endpackage

// File: hdl/hkr_queue.sv
// Two-entry job queue between the element front end and the back engine
module hkr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hkr_pkg::job_t job_in,
  output logic          full,
  input  logic          pop,
  output hkr_pkg::job_t job_out,
  output logic          empty
);
  import hkr_pkg::*;

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign job_out = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= job_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_r ^ push;
      rp_r  <= rp_r ^ pop;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

// File: hdl/hkr_front.sv
// Element front end: buffer writes, bank selection and job hand-off
module hkr_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [hkr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,
  input  logic                           in_tlast,
  input  logic [hkr_pkg::NF_W-1:0]       nf,
  input  logic                           q_full,
  output logic                           q_push,
  output hkr_pkg::job_t                  q_job,
  output hkr_pkg::smp_wr_t               smp_wr,
  input  hkr_pkg::rel_t                  rel
);
  import hkr_pkg::*;

  logic             fill_r, fill_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic             xfer;
  logic [CL_W-1:0]  lab;
  logic [FI_W-1:0]  fi;
  logic [VAL_W-1:0] val;

  assign lab       = in_tdata[3:0];
  assign fi        = in_tdata[9:4];
  assign val       = in_tdata[41:10];
  assign in_tready = !busy_r[fill_r] && !q_full;
  assign xfer      = in_tvalid && in_tready;

  always_comb begin
    smp_wr.en    = xfer && ({1'b0, fi} < nf);
    smp_wr.bank  = fill_r;
    smp_wr.idx   = fi;
    smp_wr.data  = val;
    q_push       = xfer && in_tlast;
    q_job.cmd    = cmd_t'(in_tuser);
    q_job.label  = lab;
    q_job.bank   = fill_r;
    busy_nxt     = busy_r;
    fill_nxt     = fill_r;
    if (rel.en) busy_nxt[rel.bank] = 1'b0;
    if (q_push) begin
      busy_nxt[fill_r] = 1'b1;
      fill_nxt         = ~fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 1'b0;
      busy_r <= 2'b00;
    end else begin
      fill_r <= fill_nxt;
      busy_r <= busy_nxt;
    end
  end
endmodule

// File: hdl/hkr_div.sv
// Shared restoring divider, one quotient bit per cycle, left-aligned dividend
module hkr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [hkr_pkg::DIVN_W-1:0]  dividend,
  input  logic [hkr_pkg::DIVD_W-1:0]  divisor,
  input  logic [hkr_pkg::DCNT_W-1:0]  nbits,
  output logic                        done,
  output logic [hkr_pkg::DIVN_W-1:0]  quot,
  output logic [hkr_pkg::DIVD_W-1:0]  rem
);
  import hkr_pkg::*;

  logic [DIVN_W-1:0] q_r;
  logic [DIVD_W-1:0] r_r, d_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DIVD_W:0]   tr, diff;
  logic              ge;

  assign tr   = {r_r, q_r[DIVN_W-1]};
  assign diff = tr - {1'b0, d_r};
  assign ge   = (tr >= {1'b0, d_r});
  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= {q_r[DIVN_W-2:0], ge};
      r_r <= ge ? diff[DIVD_W-1:0] : tr[DIVD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hdl/hkr_back.sv
// Back engine: cluster sums, sizes, cost walk, moves and result register
module hkr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [hkr_pkg::NC_W-1:0]       nc,
  input  logic [hkr_pkg::NF_W-1:0]       nf,
  input  logic                           q_empty,
  input  hkr_pkg::job_t                  q_job,
  output logic                           q_pop,
  input  hkr_pkg::smp_wr_t               smp_wr,
  output hkr_pkg::rel_t                  rel,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [hkr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import hkr_pkg::*;

  localparam int SMP_D = 2 * MAX_FEATURES;
  localparam int SUM_D = MAX_CLUSTERS * MAX_FEATURES;

  bk_state_t st_r, st_nxt;

  job_t                 job_r;
  logic                 skip_r, wd_r;
  logic [CL_W-1:0]      at_r, t_r, e_r, bt_r;
  logic [NF_W-1:0]      j_r;
  logic [COST_W-1:0]    acc_r, sq_r, cur_r, best_r, old_r, total_r;
  logic [SUM_W:0]       mag_r;
  logic [55:0]          p0_r, p1_r;
  logic [COST_W-1:0]    costs_r [MAX_CLUSTERS];
  logic [SIZE_BITS-1:0] size_r [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] rowv_r;
  logic [SMP_D-1:0]     sv_r, sv_nxt;
  logic [CNT_W-1:0]     moves_r;

  logic [VAL_W-1:0]     smp_mem [SMP_D];
  logic [SUM_W-1:0]     sums_mem [SUM_D];
  logic [VAL_W-1:0]     smp_q;
  logic                 smp_vq;
  logic [SUM_W-1:0]     sums_q;
  logic                 sums_vq;

  logic                 out_valid_r, out_last_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                 rd_en, wr_en, out_load;
  logic [CL_W-1:0]      rd_cl;
  logic                 div_start, div_done;
  logic [DIVN_W-1:0]    div_dividend, div_quot;
  logic [DIVD_W-1:0]    div_divisor, div_rem;
  logic [DCNT_W-1:0]    div_nbits;

  logic [SIZE_BITS-1:0] cur_n;
  logic [VAL_W-1:0]     x;
  logic [SUM_W-1:0]     sum_v, amag, x48, add_val;
  logic                 neg;
  logic [SUM_W+1:0]     q0e, qm, xe, delta, dmag;
  logic [COST_W:0]      acc_sum;
  logic                 in_range, mv_skip;
  logic                 r_last, r_moved;
  logic [CL_W-1:0]      r_label, r_cl;
  logic [COST_W-1:0]    r_cost, r_dec, tot_sum;
  logic [COST_W:0]      tot_add;

  hkr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .nbits    (div_nbits),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign cur_n    = size_r[t_r];
  assign x        = smp_vq ? smp_q : '0;
  assign x48      = {{(SUM_W-VAL_W){x[VAL_W-1]}}, x};
  assign sum_v    = sums_vq ? sums_q : '0;
  assign neg      = sum_v[SUM_W-1];
  assign amag     = neg ? (SUM_W'(0) - sum_v) : sum_v;
  assign add_val  = wd_r ? (sum_v - x48) : (sum_v + x48);
  assign q0e      = {2'b00, div_quot[SUM_W-1:0]} + (SUM_W+2)'(div_rem != '0);
  assign qm       = neg ? ((SUM_W+2)'(0) - q0e) : {2'b00, div_quot[SUM_W-1:0]};
  assign xe       = {{(SUM_W+2-VAL_W){x[VAL_W-1]}}, x};
  assign delta    = xe - qm;
  assign dmag     = delta[SUM_W+1] ? ((SUM_W+2)'(0) - delta) : delta;
  assign acc_sum  = {1'b0, acc_r} + {1'b0, sq_r};
  assign tot_add  = {1'b0, total_r} + {1'b0, best_r};
  assign tot_sum  = tot_add[COST_W] ? '1 : tot_add[COST_W-1:0];
  assign in_range = ({1'b0, q_job.label} < nc);
  assign mv_skip  = !in_range || (size_r[q_job.label] <= SIZE_BITS'(1));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          unique case (q_job.cmd)
            CMD_CLEAR:    st_nxt = BK_EMIT;
            CMD_INIT:     st_nxt = in_range ? BK_ADD_RD : BK_EMIT;
            CMD_MOVE:     st_nxt = mv_skip ? BK_EMIT : BK_ADD_RD;
            CMD_CLASSIFY: st_nxt = BK_C_START;
            default:      st_nxt = BK_IDLE;
          endcase
        end
      end
      BK_ADD_RD:  st_nxt = BK_ADD_WR;
      BK_ADD_WR:  st_nxt = (j_r == NF_W'(MAX_FEATURES - 1)) ? BK_ADD_END : BK_ADD_RD;
      BK_ADD_END: st_nxt = (job_r.cmd == CMD_MOVE && wd_r) ? BK_C_START : BK_EMIT;
      BK_C_START: st_nxt = (cur_n == '0) ? BK_C_NEXT : BK_C_RD;
      BK_C_RD:    st_nxt = BK_C_DIV;
      BK_C_DIV:   st_nxt = BK_C_DIVW;
      BK_C_DIVW:  st_nxt = div_done ? BK_C_SQ : BK_C_DIVW;
      BK_C_SQ:    st_nxt = BK_C_ACC;
      BK_C_ACC:   st_nxt = (j_r + NF_W'(1) == nf) ? BK_C_M0 : BK_C_RD;
      BK_C_M0:    st_nxt = BK_C_M1;
      BK_C_M1:    st_nxt = BK_C_FDIV;
      BK_C_FDIV:  st_nxt = BK_C_FDIVW;
      BK_C_FDIVW: st_nxt = div_done ? BK_C_NEXT : BK_C_FDIVW;
      BK_C_NEXT:  st_nxt = ({1'b0, t_r} + NC_W'(1) == nc) ? BK_C_END : BK_C_START;
      BK_C_END:   st_nxt = (job_r.cmd == CMD_MOVE) ? BK_ADD_RD : BK_EMIT;
      BK_EMIT:    st_nxt = (out_load && r_last) ? BK_IDLE : BK_EMIT;
      default:    st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = (st_r == BK_IDLE) && !q_empty;
    rd_en        = (st_r == BK_ADD_RD) || (st_r == BK_C_RD);
    rd_cl        = (st_r == BK_ADD_RD) ? at_r : t_r;
    wr_en        = (st_r == BK_ADD_WR);
    div_start    = (st_r == BK_C_DIV) || (st_r == BK_C_FDIV);
    if (st_r == BK_C_FDIV) begin
      div_dividend = {32'd0, p0_r} + {p1_r, 32'd0};
      div_divisor  = {1'b0, cur_n} + DIVD_W'(1);
      div_nbits    = DCNT_W'(DIVN_W);
    end else begin
      div_dividend = {amag, (DIVN_W-SUM_W)'(0)};
      div_divisor  = {1'b0, cur_n};
      div_nbits    = DCNT_W'(SUM_W);
    end
    out_load     = (st_r == BK_EMIT) && (!out_valid_r || out_tready);
    r_label = job_r.label;
    r_cl    = job_r.label;
    r_cost  = '0;
    r_moved = 1'b0;
    r_dec   = '0;
    r_last  = 1'b1;
    unique case (job_r.cmd)
      CMD_CLEAR: begin
        r_label = '0;
        r_cl    = '0;
      end
      CMD_INIT: begin
      end
      CMD_MOVE: begin
        if (!skip_r) begin
          r_label = bt_r;
          r_cl    = bt_r;
          r_cost  = best_r;
          r_moved = (bt_r != job_r.label);
          r_dec   = (r_moved && old_r > best_r) ? (old_r - best_r) : '0;
        end
      end
      CMD_CLASSIFY: begin
        r_label = bt_r;
        r_cl    = e_r;
        r_cost  = costs_r[e_r];
        r_last  = ({1'b0, e_r} + NC_W'(1) == nc);
      end
      default: begin
      end
    endcase
    rel.en   = out_load && r_last;
    rel.bank = job_r.bank;
  end

  always_comb begin
    sv_nxt = sv_r;
    if (rel.en) sv_nxt[{rel.bank, FI_W'(0)} +: MAX_FEATURES] = '0;
    if (smp_wr.en) sv_nxt[{smp_wr.bank, smp_wr.idx}] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (smp_wr.en) smp_mem[{smp_wr.bank, smp_wr.idx}] <= smp_wr.data;
    if (rd_en) begin
      smp_q   <= smp_mem[{job_r.bank, j_r[FI_W-1:0]}];
      sums_q  <= sums_mem[{rd_cl, j_r[FI_W-1:0]}];
    end
    if (wr_en) sums_mem[{at_r, j_r[FI_W-1:0]}] <= add_val;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      smp_vq  <= sv_r[{job_r.bank, j_r[FI_W-1:0]}];
      sums_vq <= rowv_r[rd_cl];
    end
    if (q_pop) begin
      job_r  <= q_job;
      at_r   <= q_job.label;
      wd_r   <= (q_job.cmd == CMD_MOVE);
      skip_r <= mv_skip;
      j_r    <= '0;
      t_r    <= '0;
      e_r    <= '0;
    end
    unique case (st_r)
      BK_ADD_WR:  j_r <= j_r + NF_W'(1);
      BK_ADD_END: wd_r <= 1'b0;
      BK_C_START: begin
        j_r   <= '0;
        acc_r <= '0;
        cur_r <= '0;
      end
      BK_C_DIVW: if (div_done) mag_r <= dmag[SUM_W:0];
      BK_C_SQ: begin
        sq_r <= (mag_r[SUM_W:32] != '0) ? '1 : COST_W'(mag_r[31:0] * mag_r[31:0]);
      end
      BK_C_ACC: begin
        acc_r <= acc_sum[COST_W] ? '1 : acc_sum[COST_W-1:0];
        j_r   <= j_r + NF_W'(1);
      end
      BK_C_M0:    p0_r <= 56'(acc_r[31:0] * cur_n);
      BK_C_M1:    p1_r <= 56'(acc_r[63:32] * cur_n);
      BK_C_FDIVW: if (div_done) cur_r <= div_quot[COST_W-1:0];
      BK_C_NEXT: begin
        if (t_r == '0 || cur_r < best_r) begin
          best_r <= cur_r;
          bt_r   <= t_r;
        end
        if (t_r == job_r.label) old_r <= cur_r;
        costs_r[t_r] <= cur_r;
        t_r <= t_r + CL_W'(1);
      end
      BK_C_END: begin
        at_r <= bt_r;
        j_r  <= '0;
      end
      BK_EMIT: if (out_load) e_r <= e_r + CL_W'(1);
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_r <= {7'd0, total_r, moves_r, r_dec, r_moved, r_cost, r_cl, r_label};
      out_last_r <= r_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      rowv_r      <= '0;
      sv_r        <= '0;
      moves_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_CLUSTERS; k++) size_r[k] <= '0;
    end else begin
      st_r <= st_nxt;
      sv_r <= sv_nxt;
      if (q_pop && q_job.cmd == CMD_CLEAR) begin
        rowv_r  <= '0;
        moves_r <= '0;
        total_r <= '0;
        for (int k = 0; k < MAX_CLUSTERS; k++) size_r[k] <= '0;
      end
      if (st_r == BK_ADD_END) begin
        rowv_r[at_r] <= 1'b1;
        if (wd_r) begin
          if (size_r[at_r] != '0) size_r[at_r] <= size_r[at_r] - SIZE_BITS'(1);
        end else if (size_r[at_r] != '1) begin
          size_r[at_r] <= size_r[at_r] + SIZE_BITS'(1);
        end
        if (job_r.cmd == CMD_MOVE && !wd_r && bt_r != job_r.label && moves_r != '1)
          moves_r <= moves_r + CNT_W'(1);
      end
      if (st_r == BK_C_END && job_r.cmd == CMD_CLASSIFY) total_r <= tot_sum;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
endmodule

// File: hdl/hartigan_kmeans_reassign_top.sv
// A non-final element only writes its feature. A final element runs its command:
// init a feature pass, move two feature passes plus the cost walk, classify the cost walk plus nc.
// Cost walk: per cluster in use one 48-bit division per feature plus one 88-bit division
// for the size weighting; empty clusters skip both.
// Throughput: one element per cycle while a sample bank is free; two banks overlap samples.
// Reset (synchronous, rst_n low) empties sums, sizes and counters at once through row flags.
module hartigan_kmeans_reassign_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // old_label[3:0], feature_index[9:4], value[41:10], zero pad
  input  logic [hkr_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [1:0]                     in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // label[3:0], cluster[7:4], cost[71:8], moved[72], cost_decrease[136:73],
  // change_count[160:137], cost_sum[224:161], zero pad
  output logic [hkr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [hkr_pkg::NF_W-1:0]       cfg_wdata
);
  import hkr_pkg::*;

  logic [NC_W-1:0] ncl_r, nc_eff;
  logic [NF_W-1:0] nft_r, nf_eff;
  logic            q_full, q_empty, q_push, q_pop;
  job_t            q_in, q_out;
  smp_wr_t         smp_wr;
  rel_t            rel;

  assign nc_eff = (ncl_r == '0) ? NC_W'(1) :
                  (ncl_r > NC_W'(MAX_CLUSTERS)) ? NC_W'(MAX_CLUSTERS) : ncl_r;
  assign nf_eff = (nft_r == '0) ? NF_W'(1) :
                  (nft_r > NF_W'(MAX_FEATURES)) ? NF_W'(MAX_FEATURES) : nft_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncl_r <= NC_W'(MAX_CLUSTERS);
      nft_r <= NF_W'(MAX_FEATURES);
    end else if (cfg_we) begin
      if (cfg_index == REG_CLUSTERS) ncl_r <= cfg_wdata[NC_W-1:0];
      if (cfg_index == REG_FEATURES) nft_r <= cfg_wdata;
    end
  end

  hkr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .nf        (nf_eff),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_in),
    .smp_wr    (smp_wr),
    .rel       (rel)
  );

  hkr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .job_in  (q_in),
    .full    (q_full),
    .pop     (q_pop),
    .job_out (q_out),
    .empty   (q_empty)
  );

  hkr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .nc         (nc_eff),
    .nf         (nf_eff),
    .q_empty    (q_empty),
    .q_job      (q_out),
    .q_pop      (q_pop),
    .smp_wr     (smp_wr),
    .rel        (rel),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );
endmodule

// File: hdl/hkr_checker.sv
// Port-level checker for the k-means reassignment block, bound to the top level
`include "hartigan_kmeans_reassign_top_macros.svh"

module hkr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [hkr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);
  `HKR_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `HKR_ASSERT_RST(a_out_reset, !out_tvalid, "result valid right after reset")
  `HKR_ASSERT_IMP(a_move_count, out_tvalid && out_tdata[72], out_tdata[160:137] != 24'd0, "move reported with zero move count")
  `HKR_ASSERT_IMP(a_move_single, out_tvalid && out_tdata[72], out_tlast && (out_tdata[3:0] == out_tdata[7:4]), "move result not a single labeled result")
endmodule

bind hartigan_kmeans_reassign_top hkr_checker u_hkr_checker (.*);

// File: dv/tb_hartigan_kmeans_reassign_top.sv
// Self-checking testbench for the k-means reassignment block: random and directed samples
module tb_hartigan_kmeans_reassign_top;
  import hkr_pkg::*;

  typedef struct {
    cmd_t             cmd;
    logic [3:0]       lab;
    logic [5:0]       fi;
    logic [31:0]      val;
    logic             last;
  } elem_t;

  typedef struct packed {
    logic [3:0]  label;
    logic [3:0]  cluster;
    logic [63:0] cost;
    logic        moved;
    logic [63:0] dec;
    logic [23:0] moves;
    logic [63:0] total;
    logic        lastr;
  } res_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid, out_tready, out_tlast;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we, cfg_index;
  logic [NF_W-1:0] cfg_wdata;

  hartigan_kmeans_reassign_top u_dut (.*);

  elem_t pending_elems[$];
  res_t  expected_results[$];
  int    send_idle_pct, recv_stall_pct;
  bit    hold_active = 1'b0;
  int    fail_count = 0;
  longint cycle_count = 0;

  // predictor state
  int          nclus, nfeat;
  logic [47:0] sums[MAX_CLUSTERS][MAX_FEATURES];
  logic [23:0] sizes[MAX_CLUSTERS];
  logic [31:0] samp[MAX_FEATURES];
  logic [23:0] moves;
  logic [63:0] total;

  function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] weighted_cost(int t);
    logic [63:0] acc, mag;
    longint s, n, q, d;
    logic [127:0] w;
    acc = 0;
    n = sizes[t];
    if (n == 0) return 0;
    for (int j = 0; j < nfeat; j++) begin
      s = $signed(sums[t][j]);
      q = s / n;
      if (s % n != 0 && s < 0) q--;
      d = longint'($signed(samp[j])) - q;
      mag = d < 0 ? -d : d;
      acc = sadd(acc, mag >= 64'h1_0000_0000 ? '1 : mag * mag);
    end
    w = {64'd0, acc} * n;
    w = w / (n + 1);
    return w[63:0];
  endfunction

  function automatic void fold_sample(int t, bit withdraw);
    for (int j = 0; j < nfeat; j++)
      sums[t][j] = withdraw ? sums[t][j] - {{16{samp[j][31]}}, samp[j]}
                            : sums[t][j] + {{16{samp[j][31]}}, samp[j]};
    if (withdraw) begin
      if (sizes[t] > 0) sizes[t]--;
    end else if (sizes[t] != '1) begin
      sizes[t]++;
    end
  endfunction

  function automatic void clear_model();
    foreach (sums[i, j]) sums[i][j] = 0;
    foreach (sizes[i]) sizes[i] = 0;
    foreach (samp[j]) samp[j] = 0;
    moves = 0;
    total = 0;
  endfunction

  function automatic void push_res(logic [3:0] l, logic [3:0] c, logic [63:0] cost,
                                   logic mv, logic [63:0] dec, logic lr);
    res_t r;
    r.label = l; r.cluster = c; r.cost = cost; r.moved = mv; r.dec = dec;
    r.moves = moves; r.total = total; r.lastr = lr;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_element(elem_t e);
    logic [63:0] costs[MAX_CLUSTERS];
    logic [63:0] best, oldc;
    int bt;
    if (e.fi < nfeat) samp[e.fi] = e.val;
    if (!e.last) return;
    case (e.cmd)
      CMD_CLEAR: begin
        clear_model();
        push_res(4'd0, 4'd0, 64'd0, 1'b0, 64'd0, 1'b1);
        return;
      end
      CMD_INIT: begin
        if (e.lab < nclus) fold_sample(e.lab, 0);
        push_res(e.lab, e.lab, 64'd0, 1'b0, 64'd0, 1'b1);
      end
      CMD_MOVE: begin
        if (e.lab >= nclus || sizes[e.lab] <= 1) begin
          push_res(e.lab, e.lab, 64'd0, 1'b0, 64'd0, 1'b1);
        end else begin
          fold_sample(e.lab, 1);
          best = 0; oldc = 0; bt = 0;
          for (int t = 0; t < nclus; t++) begin
            costs[t] = weighted_cost(t);
            if (t == 0 || costs[t] < best) begin best = costs[t]; bt = t; end
            if (t == e.lab) oldc = costs[t];
          end
          fold_sample(bt, 0);
          if (bt != e.lab) begin
            if (moves != '1) moves++;
            push_res(4'(bt), 4'(bt), best, 1'b1, oldc > best ? oldc - best : 64'd0, 1'b1);
          end else begin
            push_res(4'(bt), 4'(bt), best, 1'b0, 64'd0, 1'b1);
          end
        end
      end
      default: begin
        best = 0; bt = 0;
        for (int t = 0; t < nclus; t++) begin
          costs[t] = weighted_cost(t);
          if (t == 0 || costs[t] < best) begin best = costs[t]; bt = t; end
        end
        total = sadd(total, best);
        for (int t = 0; t < nclus; t++)
          push_res(4'(bt), 4'(t), costs[t], 1'b0, 64'd0, t + 1 == nclus);
      end
    endcase
    foreach (samp[j]) samp[j] = 0;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      in_tlast  <= 0;
      clear_model();
    end else begin
      if (in_tvalid && in_tready) predict_element(pending_elems.pop_front());
      if ((!in_tvalid || in_tready)) begin
        if (pending_elems.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1;
          in_tdata  <= {6'd0, pending_elems[0].val, pending_elems[0].fi, pending_elems[0].lab};
          in_tuser  <= pending_elems[0].cmd;
          in_tlast  <= pending_elems[0].last;
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t exp_r, got;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.label = out_tdata[3:0]; got.cluster = out_tdata[7:4];
        got.cost = out_tdata[71:8]; got.moved = out_tdata[72];
        got.dec = out_tdata[136:73]; got.moves = out_tdata[160:137];
        got.total = out_tdata[224:161]; got.lastr = out_tlast;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result label=%h cost=%h", $time, got.label, got.cost);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got != exp_r) begin
            $display("%0t: mismatch exp l=%h c=%h cost=%h mv=%b dec=%h cnt=%h tot=%h lr=%b",
                     $time, exp_r.label, exp_r.cluster, exp_r.cost, exp_r.moved, exp_r.dec,
                     exp_r.moves, exp_r.total, exp_r.lastr);
            $display("%0t:     got l=%h c=%h cost=%h mv=%b dec=%h cnt=%h tot=%h lr=%b",
                     $time, got.label, got.cluster, got.cost, got.moved, got.dec,
                     got.moves, got.total, got.lastr);
            fail_count++;
          end
        end
      end
      if (hold_active) out_tready <= 0;
      else out_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // hold off the receiver for as long as the argument asks
  task automatic long_hold(int cycles);
    hold_active <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_active <= 1'b0;
  endtask

  task automatic write_reg(logic idx, int v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= NF_W'(v);
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_CLUSTERS) nclus = v < 1 ? 1 : (v > 16 ? 16 : v);
    else nfeat = v < 1 ? 1 : (v > 64 ? 64 : v);
  endtask

  task automatic add_elem(cmd_t c, int lab, int fi, logic [31:0] v, bit l);
    elem_t e;
    e.cmd = c; e.lab = 4'(lab); e.fi = 6'(fi); e.val = v; e.last = l;
    pending_elems.push_back(e);
  endtask

  task automatic add_sample(cmd_t c, int lab, int nel, bit wide);
    logic [31:0] v;
    for (int k = 0; k < nel; k++) begin
      v = wide ? $urandom : 32'($signed($urandom_range(0, 2 ** 19)) - 2 ** 18);
      add_elem(c, lab, $urandom_range(0, (k % 4 == 3) ? 63 : nfeat - 1), v, k == nel - 1);
    end
  endtask

  task automatic drain();
    while (pending_elems.size() > 0 || expected_results.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic random_phase(int samples);
    int r;
    for (int s = 0; s < samples; s++) begin
      r = $urandom_range(99);
      if (r < 40) add_sample(CMD_INIT, $urandom_range(0, 15), $urandom_range(1, 3), r < 4);
      else if (r < 75) add_sample(CMD_MOVE, $urandom_range(0, 15), $urandom_range(1, 3), r < 44);
      else if (r < 97) add_sample(CMD_CLASSIFY, $urandom_range(0, 15), $urandom_range(1, 3),
                                  r < 78);
      else add_sample(CMD_CLEAR, $urandom_range(0, 15), 1, 1);
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    nclus = 16; nfeat = 64;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, every command, skip, saturation-prone values
    write_reg(REG_CLUSTERS, 2);
    write_reg(REG_FEATURES, 1);
    add_elem(CMD_MOVE, 0, 0, 32'h7fffffff, 1);
    add_elem(CMD_INIT, 0, 0, 32'h7fffffff, 1);
    add_elem(CMD_INIT, 0, 0, 32'h80000000, 1);
    add_elem(CMD_INIT, 15, 63, 32'h1, 1);
    add_elem(CMD_INIT, 1, 0, 32'h80000000, 1);
    add_elem(CMD_CLASSIFY, 1, 0, 32'h7fffffff, 1);
    add_elem(CMD_MOVE, 0, 0, 32'h7fffffff, 1);
    add_elem(CMD_MOVE, 1, 0, 32'h0, 1);
    add_elem(CMD_INIT, 0, 5, 32'hffffffff, 0);
    add_elem(CMD_INIT, 0, 0, 32'h12345678, 1);
    add_elem(CMD_MOVE, 0, 0, 32'h0, 1);
    add_elem(CMD_CLASSIFY, 0, 0, 32'h0, 1);
    add_elem(CMD_CLEAR, 0, 0, 32'h0, 1);
    add_elem(CMD_CLASSIFY, 0, 0, 32'h0, 1);
    drain();

    write_reg(REG_CLUSTERS, 0);
    write_reg(REG_FEATURES, 0);
    random_phase(22);
    drain();
    write_reg(REG_CLUSTERS, 31);
    write_reg(REG_FEATURES, 127);
    random_phase(6);
    drain();

    write_reg(REG_CLUSTERS, 4);
    write_reg(REG_FEATURES, 3);
    random_phase(44);
    drain();

    send_idle_pct = 53;
    write_reg(REG_CLUSTERS, 3);
    write_reg(REG_FEATURES, 2);
    random_phase(44);
    drain();

    send_idle_pct = 0; recv_stall_pct = 53;
    write_reg(REG_CLUSTERS, 5);
    random_phase(44);
    fork
      long_hold(4000);
    join_none
    drain();

    send_idle_pct = 21; recv_stall_pct = 21;
    write_reg(REG_CLUSTERS, 2);
    write_reg(REG_FEATURES, 4);
    random_phase(60);
    drain();

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    wait (cycle_count == 5_000_000);
    $display("Test completed with failures");
    $finish;
  end
endmodule
